[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the framed packet transmitter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising clock edge outside reset
`define FPUT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fput assertion failed");

// cond must never be true outside reset
`define FPUT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("fput forbidden condition seen");

`endif

[hw/rtl/fput_pkg.sv]
// ----------------------------------------------------------------------------
// fput_pkg
// Shared types, frame constants and the frame byte lookup.
// ----------------------------------------------------------------------------
package fput_pkg;

	localparam logic [7:0] FRAME_HEAD = 8'hAA;
	localparam logic [7:0] FRAME_TAIL = 8'hAB;
	localparam logic [7:0] FRAME_PAD  = 8'h00;

	localparam logic [2:0] IDX_HEAD   = 3'd0;
	localparam logic [2:0] IDX_SWITCH = 3'd1;
	localparam logic [2:0] IDX_WIND   = 3'd2;
	localparam logic [2:0] IDX_PAD    = 3'd3;
	localparam logic [2:0] IDX_CHECK  = 3'd4;
	localparam logic [2:0] IDX_LAST   = 3'd5;

	localparam logic [3:0] PHASE_START = 4'd0;
	localparam logic [3:0] PHASE_STOP  = 4'd9;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SEND = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] switch_data;
		logic [7:0] wind_data;
	} in_word_t;

	typedef struct packed {
		logic tx_line;
		logic busy_res;
		logic frame_done;
		logic request_dropped;
	} out_word_t;

	function automatic logic [7:0] frame_byte(input logic [2:0] idx,
		input logic [7:0] sw, input logic [7:0] wd, input logic [7:0] chk);
		logic [7:0] b;
		unique case (idx)
			IDX_HEAD:   b = FRAME_HEAD;
			IDX_SWITCH: b = sw;
			IDX_WIND:   b = wd;
			IDX_PAD:    b = FRAME_PAD;
			IDX_CHECK:  b = chk;
			default:    b = FRAME_TAIL;
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/fput_stream_if.sv]
// ----------------------------------------------------------------------------
// fput_in_if / fput_out_if
// Valid/ready channels for send/tick words and line status words.
// ----------------------------------------------------------------------------
interface fput_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] switch_data;
	logic [7:0] wind_data;

	modport source (output valid, output action, output switch_data,
		output wind_data, input ready);
	modport sink (input valid, input action, input switch_data,
		input wind_data, output ready);
endinterface

interface fput_out_if;
	logic valid;
	logic ready;
	logic tx_line;
	logic busy_res;
	logic frame_done;
	logic request_dropped;

	modport source (output valid, output tx_line, output busy_res,
		output frame_done, output request_dropped, input ready);
	modport sink (input valid, input tx_line, input busy_res,
		input frame_done, input request_dropped, output ready);
endinterface

[hw/rtl/fput_frame_core.sv]
// ----------------------------------------------------------------------------
// fput_frame_core
// Frame sequencer: byte index, bit phase, shift byte and line level.
// ----------------------------------------------------------------------------
module fput_frame_core
	import fput_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	output out_word_t res
);

	logic       sending_q, sending_d;
	logic [2:0] idx_q, idx_d;
	logic [3:0] phase_q, phase_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] sw_q, sw_d;
	logic [7:0] wd_q, wd_d;
	logic [7:0] chk_q, chk_d;
	logic       line_q, line_d;
	logic       done, dropped;

	always_comb begin
		sending_d = sending_q;
		idx_d     = idx_q;
		phase_d   = phase_q;
		shift_d   = shift_q;
		sw_d      = sw_q;
		wd_d      = wd_q;
		chk_d     = chk_q;
		line_d    = line_q;
		done      = 1'b0;
		dropped   = 1'b0;
		if (word.action == ACT_SEND) begin
			if (sending_q) begin
				dropped = 1'b1;
			end else begin
				sw_d      = word.switch_data;
				wd_d      = word.wind_data;
				chk_d     = FRAME_HEAD ^ word.switch_data ^ word.wind_data ^ FRAME_PAD;
				idx_d     = IDX_HEAD;
				phase_d   = PHASE_START;
				shift_d   = 8'h00;
				sending_d = 1'b1;
			end
		end else if (sending_q) begin
			if (phase_q == PHASE_START) begin
				shift_d = frame_byte(idx_q, sw_q, wd_q, chk_q);
				line_d  = 1'b0;
				phase_d = phase_q + 4'd1;
			end else if (phase_q < PHASE_STOP) begin
				line_d  = shift_q[0];
				shift_d = {1'b0, shift_q[7:1]};
				phase_d = phase_q + 4'd1;
			end else if (phase_q == PHASE_STOP) begin
				line_d  = 1'b1;
				phase_d = phase_q + 4'd1;
			end else begin
				line_d  = 1'b1;
				phase_d = PHASE_START;
				if (idx_q >= IDX_LAST) begin
					idx_d     = IDX_HEAD;
					sending_d = 1'b0;
					done      = 1'b1;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			idx_q     <= IDX_HEAD;
			phase_q   <= PHASE_START;
			shift_q   <= 8'h00;
			sw_q      <= 8'h00;
			wd_q      <= 8'h00;
			chk_q     <= 8'h00;
			line_q    <= 1'b1;
		end else if (step) begin
			sending_q <= sending_d;
			idx_q     <= idx_d;
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			sw_q      <= sw_d;
			wd_q      <= wd_d;
			chk_q     <= chk_d;
			line_q    <= line_d;
		end
	end

	assign res = '{tx_line: line_d, busy_res: sending_d, frame_done: done,
		request_dropped: dropped};

endmodule

[hw/rtl/fput_out_buf.sv]
// ----------------------------------------------------------------------------
// fput_out_buf
// Two-entry result buffer between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module fput_out_buf
	import fput_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  out_word_t wr_word,
	output logic      wr_ready,
	fput_out_if.source out_ch
);

	out_word_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       rd_en;
	out_word_t  rd_word;

	assign rd_en    = out_ch.valid && out_ch.ready;
	assign wr_ready = (count_q != 2'd2) || out_ch.ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	assign rd_word                = mem_q[rd_ptr_q];
	assign out_ch.valid           = (count_q != 2'd0);
	assign out_ch.tx_line         = rd_word.tx_line;
	assign out_ch.busy_res        = rd_word.busy_res;
	assign out_ch.frame_done      = rd_word.frame_done;
	assign out_ch.request_dropped = rd_word.request_dropped;

endmodule

[hw/rtl/framed_packet_uart_transmitter_top.sv]
// ----------------------------------------------------------------------------
// framed_packet_uart_transmitter_top
// 8N2 serial frame transmitter: AA, switch, wind, 00, XOR check, AB.
// ----------------------------------------------------------------------------
// A word accepted into the input register steps the sequencer; its result word
// goes to a two-entry result buffer that absorbs output stalls. Throughput: one
// word per cycle while that buffer can take a result, else the input stalls.
// Reset: arst_n clears the sequencer to idle with the line high and empties
// the input register and result buffer.
module framed_packet_uart_transmitter_top
	import fput_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fput_in_if.sink    in_ch,
	fput_out_if.source out_ch
);

	in_word_t  word_s1;
	logic      valid_s1;
	logic      buf_ready;
	logic      adv;
	out_word_t res;

	assign adv         = valid_s1 && buf_ready;
	assign in_ch.ready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			word_s1 <= '{action: in_ch.action, switch_data: in_ch.switch_data,
				wind_data: in_ch.wind_data};
		end
	end

	fput_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.word   (word_s1),
		.res    (res)
	);

	fput_out_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (adv),
		.wr_word  (res),
		.wr_ready (buf_ready),
		.out_ch   (out_ch)
	);

endmodule

[hw/rtl/fput_checker.sv]
// ----------------------------------------------------------------------------
// fput_checker
// Port-level checks on the transmitter's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fput_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic tx_line,
	input logic busy_res,
	input logic frame_done,
	input logic request_dropped
);

	logic       out_acc;
	logic [3:0] out_bits;
	assign out_acc  = out_valid && out_ready;
	assign out_bits = {tx_line, busy_res, frame_done, request_dropped};

	`FPUT_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_bits)))
	`FPUT_ASSERT(a_done_idle, clk, arst_n, (out_acc && frame_done) |-> (!busy_res && tx_line))
	`FPUT_ASSERT(a_drop_busy, clk, arst_n, (out_acc && request_dropped) |-> (busy_res && !frame_done))
	`FPUT_NEVER(a_idle_low, clk, arst_n, out_acc && !busy_res && !tx_line)

endmodule

bind framed_packet_uart_transmitter_top fput_checker u_fput_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.tx_line         (out_ch.tx_line),
	.busy_res        (out_ch.busy_res),
	.frame_done      (out_ch.frame_done),
	.request_dropped (out_ch.request_dropped)
);

[dv/framed_packet_uart_transmitter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_uart_transmitter_top_tb
// Self-checking bench for the framed 8N2 transmitter. A line model predicts
// the line level, busy, frame-done and dropped-request flags for every
// accepted tick or send word. It runs directed frames first, then random
// frames, broken frames and noise, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module framed_packet_uart_transmitter_top_tb;
	import fput_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int FRAME_TICKS    = 66;
	localparam int RANDOM_WORDS   = 1200;
	localparam int LONG_HOLD      = 250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 12;
	localparam int REPORT_LIMIT   = 20;

	class frame_line_scoreboard;
		logic       sending;
		logic [2:0] byte_idx;
		logic [3:0] phase;
		logic [7:0] shifter;
		logic [7:0] held_sw;
		logic [7:0] held_wd;
		logic [7:0] chk;
		logic       line;
		out_word_t  line_status_q[$];
		int         errors;

		function void clear();
			sending  = 1'b0;
			byte_idx = IDX_HEAD;
			phase    = PHASE_START;
			shifter  = '0;
			held_sw  = '0;
			held_wd  = '0;
			chk      = '0;
			line     = 1'b1;
			errors   = 0;
			line_status_q.delete();
		endfunction

		function int outstanding();
			return line_status_q.size();
		endfunction

		function void note_word(in_word_t w);
			out_word_t e;
			e = '0;
			if (w.action == ACT_SEND) begin
				if (sending) begin
					e.request_dropped = 1'b1;
				end else begin
					held_sw  = w.switch_data;
					held_wd  = w.wind_data;
					chk      = FRAME_HEAD ^ held_sw ^ held_wd ^ FRAME_PAD;
					byte_idx = IDX_HEAD;
					phase    = PHASE_START;
					shifter  = '0;
					sending  = 1'b1;
				end
			end else if (sending) begin
				if (phase == PHASE_START) begin
					case (byte_idx)
						IDX_HEAD:   shifter = FRAME_HEAD;
						IDX_SWITCH: shifter = held_sw;
						IDX_WIND:   shifter = held_wd;
						IDX_PAD:    shifter = FRAME_PAD;
						IDX_CHECK:  shifter = chk;
						default:    shifter = FRAME_TAIL;
					endcase
					line  = 1'b0;
					phase = phase + 4'd1;
				end else if (phase < PHASE_STOP) begin
					line    = shifter[0];
					shifter = shifter >> 1;
					phase   = phase + 4'd1;
				end else if (phase == PHASE_STOP) begin
					line  = 1'b1;
					phase = phase + 4'd1;
				end else begin
					line  = 1'b1;
					phase = PHASE_START;
					if (byte_idx >= IDX_LAST) begin
						byte_idx     = IDX_HEAD;
						sending      = 1'b0;
						e.frame_done = 1'b1;
					end else begin
						byte_idx = byte_idx + 3'd1;
					end
				end
			end
			e.tx_line  = line;
			e.busy_res = sending;
			line_status_q.push_back(e);
		endfunction

		function void compare_bit(string field, logic exp_v, logic got_v);
			if (got_v !== exp_v) begin
				if (errors < REPORT_LIMIT)
					$error("%s: expected %0b, got %0b", field, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t e;
			if (line_status_q.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$error("unexpected status word %b", got);
				errors++;
				return;
			end
			e = line_status_q.pop_front();
			compare_bit("tx_line", e.tx_line, got.tx_line);
			compare_bit("busy_res", e.busy_res, got.busy_res);
			compare_bit("frame_done", e.frame_done, got.frame_done);
			compare_bit("request_dropped", e.request_dropped, got.request_dropped);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fput_in_if  in_ch();
	fput_out_if out_ch();

	frame_line_scoreboard sb;

	int  hold_req;
	int  stall_left;
	int  ready_gap;
	bit  calm;
	int  quiet_cycles;

	framed_packet_uart_transmitter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// sample both channels and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (in_ch.valid && in_ch.ready) begin
				sb.note_word({in_ch.action, in_ch.switch_data, in_ch.wind_data});
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_word({out_ch.tx_line, out_ch.busy_res, out_ch.frame_done,
					out_ch.request_dropped});
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold when requested
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
			end else if (ready_gap > 0) begin
				out_ch.ready <= 1'b0;
				ready_gap--;
			end else begin
				out_ch.ready <= 1'b1;
				ready_gap = gap_len();
			end
		end
	end

	task automatic put_word(logic act, logic [7:0] sw, logic [7:0] wd);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid       <= 1'b1;
		in_ch.action      <= act;
		in_ch.switch_data <= sw;
		in_ch.wind_data   <= wd;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic run_ticks(int n);
		repeat (n) put_word(ACT_TICK, 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		int  sent;
		int  frames;
		int  n;
		bit  hold_done;
		bit  drain_done;

		sb = new;
		sb.clear();
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.action      = ACT_TICK;
		in_ch.switch_data = '0;
		in_ch.wind_data   = '0;
		out_ch.ready      = 1'b0;
		hold_req          = 0;
		stall_left        = 0;
		ready_gap         = 0;
		calm              = 1'b0;
		quiet_cycles      = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed: idle ticks, extremes, dropped requests
		run_ticks(2);
		put_word(ACT_SEND, 8'h00, 8'h00);
		put_word(ACT_SEND, 8'hFF, 8'hFF);
		run_ticks(FRAME_TICKS);
		run_ticks(1);
		put_word(ACT_SEND, 8'hFF, 8'hFF);
		run_ticks(30);
		put_word(ACT_SEND, 8'h12, 8'h34);
		run_ticks(FRAME_TICKS - 30);
		put_word(ACT_SEND, 8'h55, 8'hAA);
		run_ticks(FRAME_TICKS - 1);
		put_word(ACT_SEND, 8'hAA, 8'h55);
		run_ticks(1);
		put_word(ACT_SEND, 8'hAA, 8'h00);
		run_ticks(FRAME_TICKS);
		drain();

		// random: mostly whole frames, some broken frames and noise
		sent       = 0;
		frames     = 0;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		while (sent < RANDOM_WORDS) begin
			calm = ($urandom_range(0, 5) == 0);
			if (frames >= 4 && !hold_done) begin
				hold_req  = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (frames >= 8 && !drain_done) begin
				drain();
				drain_done = 1'b1;
			end
			if ($urandom_range(0, 4) != 0) begin
				put_word(ACT_SEND, 8'($urandom), 8'($urandom));
				sent++;
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, FRAME_TICKS - 1)
					: FRAME_TICKS;
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 24) == 0) begin
						put_word(ACT_SEND, 8'($urandom), 8'($urandom));
						sent++;
					end
					put_word(ACT_TICK, 8'($urandom), 8'($urandom));
					sent++;
				end
				frames++;
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					put_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
					sent++;
				end
			end
		end

		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
